### hdl/rsg_pkg.sv
// rsg_pkg: shared constants, codes and handshake structs of the random generator
// used by rsg_serial_mul, rsg_serial_mod and xorshift_star_random_generator_unit
// no dependencies
`default_nettype none
package rsg_pkg;

   // operand and field widths
   localparam int unsigned WordW   = 64;
   localparam int unsigned IntW    = 32;
   localparam int unsigned SpanW   = IntW + 1;
   localparam int unsigned ProbW   = 25;
   localparam int unsigned FracW   = ProbW - 1;
   localparam int unsigned StreamW = 8;
   localparam int unsigned StepW   = $clog2(WordW);
   localparam int unsigned CsrAddrW = 5;
   localparam int unsigned CsrDataW = 64;
   localparam int unsigned ReqDataW = 96;
   localparam int unsigned RspDataW = 104;

   // mixing and scrambling constants
   localparam logic [WordW-1:0] SEED_GAMMA   = 64'h9E3779B97F4A7C15;
   localparam logic [WordW-1:0] MIX_A        = 64'hBF58476D1CE4E5B9;
   localparam logic [WordW-1:0] MIX_B        = 64'h94D049BB133111EB;
   localparam logic [WordW-1:0] STREAM_MUL   = 64'hD6E8FEB86659FD93;
   localparam logic [WordW-1:0] VARIANT_MUL  = 64'hA24BAED4963EE407;
   localparam logic [WordW-1:0] SCRAMBLE     = 64'h2545F4914F6CDD1D;

   // request opcodes
   typedef enum logic [1:0] {
      OP_RESEED  = 2'd0,
      OP_DRAW    = 2'd1,
      OP_INTEGER = 2'd2,
      OP_CHANCE  = 2'd3
   } op_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      CSR_IDENTITY = 2'd0,
      CSR_STREAM   = 2'd1,
      CSR_VARIANT  = 2'd2
   } csr_index_type;

   // serial multiplier handshake
   typedef struct packed {
      logic             start;
      logic [WordW-1:0] a;
      logic [WordW-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [WordW-1:0] product;
   } mul_rsp_type;

   // serial modulo handshake
   typedef struct packed {
      logic             start;
      logic [WordW-1:0] dividend;
      logic [SpanW-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic            done;
      logic [IntW-1:0] remainder;
   } mod_rsp_type;

endpackage
`default_nettype wire

### hdl/rsg_serial_mul.sv
// rsg_serial_mul: bit-serial 64 x 64 multiplier, low 64 bits of the product
// one multiplier bit per cycle; depends on rsg_pkg
`default_nettype none
module rsg_serial_mul (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsg_pkg::mul_req_type mul_req,
   output rsg_pkg::mul_rsp_type     mul_rsp
);
   import rsg_pkg::*;

   logic [WordW-1:0] mcand_ff;
   logic [WordW-1:0] mplier_ff;
   logic [WordW-1:0] acc_ff;
   logic [WordW-1:0] acc_in;
   logic [StepW-1:0] step_ff;
   logic             busy_ff;
   logic             done_ff;

   // add the shifted multiplicand when the current multiplier bit is set
   always_comb begin
      acc_in = mplier_ff[0] ? (acc_ff + mcand_ff) : acc_ff;
   end

   // shift-add sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            mcand_ff  <= mul_req.a;
            mplier_ff <= mul_req.b;
            acc_ff    <= '0;
            step_ff   <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            acc_ff    <= acc_in;
            mcand_ff  <= {mcand_ff[WordW-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[WordW-1:1]};
            step_ff   <= step_ff + StepW'(1);
            if (step_ff == StepW'(WordW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule
`default_nettype wire

### hdl/rsg_serial_mod.sv
// rsg_serial_mod: restoring remainder of a 64-bit word by a span of up to 2^32
// one dividend bit per cycle; depends on rsg_pkg
`default_nettype none
module rsg_serial_mod (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsg_pkg::mod_req_type mod_req,
   output rsg_pkg::mod_rsp_type     mod_rsp
);
   import rsg_pkg::*;

   logic [WordW-1:0] dvd_ff;
   logic [SpanW-1:0] den_ff;
   logic [SpanW-1:0] rem_ff;
   logic [SpanW:0]   trial;
   logic [SpanW-1:0] rem_in;
   logic [StepW-1:0] step_ff;
   logic             busy_ff;
   logic             done_ff;

   // bring down the next dividend bit and subtract when it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[WordW-1]};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = SpanW'(trial - {1'b0, den_ff});
      end else begin
         rem_in = trial[SpanW-1:0];
      end
   end

   // one quotient step per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mod_req.start) begin
            dvd_ff  <= mod_req.dividend;
            den_ff  <= mod_req.divisor;
            rem_ff  <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            dvd_ff  <= {dvd_ff[WordW-2:0], 1'b0};
            step_ff <= step_ff + StepW'(1);
            if (step_ff == StepW'(WordW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder is below the span, so it fits in the low 32 bits
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[IntW-1:0];

endmodule
`default_nettype wire

### hdl/xorshift_star_random_generator_unit.sv
// xorshift_star_random_generator_unit: xorshift64* generator with splitmix64 reseed
// a draw or chance runs the scramble multiply, an integer adds the serial modulo,
// a reseed runs the stream, variant and both mixing multiplies, and trivial requests
// skip the serial arithmetic; one request in flight at a time
// reset: configuration registers clear to zero, then a seeding pass
// derives the state from the reset register values; req_tready stays low until it ends
`default_nettype none
module xorshift_star_random_generator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // op[1:0], range_low[33:2], range_high[65:34], chance_probability[90:66], zero fill
   input  wire logic [rsg_pkg::ReqDataW-1:0]      req_tdata,
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // raw_value[63:0], integer_value[95:64], hit[96], advanced[97], zero fill
   output logic [rsg_pkg::RspDataW-1:0]           rsp_tdata,
   // csr port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [rsg_pkg::CsrAddrW-1:0]      csr_paddr,
   input  wire logic [rsg_pkg::CsrDataW-1:0]      csr_pwdata,
   output logic [rsg_pkg::CsrDataW-1:0]           csr_prdata,
   output logic                                   csr_pready
);
   import rsg_pkg::*;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_STREAM_MUL,
      S_VARIANT_MUL,
      S_MIX_A,
      S_MIX_B,
      S_SCRAMBLE,
      S_MODULO,
      S_FINISH
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [WordW-1:0]   identity_ff;
   logic [StreamW-1:0] stream_ff;
   logic [IntW-1:0]    variant_ff;

   // generator and work registers
   logic [WordW-1:0] gen_state_ff;
   logic [WordW-1:0] work_ff;
   logic             init_ff;
   op_type           op_ff;
   logic [IntW-1:0]  low_ff;
   logic [SpanW-1:0] span_ff;
   logic [FracW-1:0] prob_ff;

   // pending result
   logic [WordW-1:0] res_raw_ff;
   logic [IntW-1:0]  res_int_ff;
   logic             res_hit_ff;
   logic             res_adv_ff;

   // output register
   logic                rsp_valid_ff;
   logic [RspDataW-1:0] rsp_data_ff;

   // serial unit handshakes
   mul_req_type mul_req_ff;
   mul_rsp_type mul_rsp;
   mod_req_type mod_req_ff;
   mod_rsp_type mod_rsp;

   // request fields
   op_type           req_op;
   logic [IntW-1:0]  req_low;
   logic [IntW-1:0]  req_high;
   logic [ProbW-1:0] req_prob;
   logic [SpanW-1:0] req_span;
   logic             range_empty;
   logic             req_accept;

   // datapath helpers
   logic [WordW-1:0] xs_a;
   logic [WordW-1:0] xs_b;
   logic [WordW-1:0] xs_next;
   logic [WordW-1:0] seed_z;
   logic [WordW-1:0] init_z;
   logic [WordW-1:0] mix_a_op;
   logic [WordW-1:0] init_a_op;
   logic [WordW-1:0] mix_b_op;
   logic [WordW-1:0] mix_out;
   logic             out_free;
   logic             csr_write;

   // serial arithmetic units
   rsg_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   rsg_serial_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req_ff),
      .mod_rsp (mod_rsp)
   );

   // request decode
   always_comb begin
      req_op      = op_type'(req_tdata[1:0]);
      req_low     = req_tdata[33:2];
      req_high    = req_tdata[65:34];
      req_prob    = req_tdata[90:66];
      req_span    = SpanW'({req_high[IntW-1], req_high} - {req_low[IntW-1], req_low}
                           + SpanW'(1));
      range_empty = $signed(req_high) <= $signed(req_low);
      req_accept  = req_tvalid && req_tready;
   end

   // xorshift step and splitmix mixing terms
   always_comb begin
      xs_a      = gen_state_ff ^ (gen_state_ff >> 12);
      xs_b      = xs_a ^ (xs_a << 25);
      xs_next   = xs_b ^ (xs_b >> 27);
      seed_z    = (work_ff ^ mul_rsp.product) + SEED_GAMMA;
      mix_a_op  = seed_z ^ (seed_z >> 30);
      init_z    = VARIANT_MUL + SEED_GAMMA;
      init_a_op = init_z ^ (init_z >> 30);
      mix_b_op  = mul_rsp.product ^ (mul_rsp.product >> 27);
      mix_out   = mul_rsp.product ^ (mul_rsp.product >> 31);
      out_free  = !rsp_valid_ff || rsp_tready;
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_INIT;
         init_ff          <= 1'b1;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         mod_req_ff.start <= 1'b0;
      end else begin
         // hand the result to the output register once it is free
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= {6'b0, res_adv_ff, res_hit_ff, res_int_ff, res_raw_ff};
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            // seed from the reset register values
            S_INIT: begin
               mul_req_ff       <= '{start: 1'b1, a: init_a_op, b: MIX_A};
               mod_req_ff.start <= 1'b0;
               state_ff         <= S_MIX_A;
            end
            S_IDLE: begin
               mod_req_ff.start <= 1'b0;
               if (req_accept) begin
                  op_ff      <= req_op;
                  low_ff     <= req_low;
                  span_ff    <= req_span;
                  prob_ff    <= req_prob[FracW-1:0];
                  res_raw_ff <= '0;
                  res_adv_ff <= 1'b0;
                  priority if (req_op == OP_RESEED) begin
                     res_int_ff <= '0;
                     res_hit_ff <= 1'b0;
                     mul_req_ff <= '{start: 1'b1, a: WordW'(stream_ff), b: STREAM_MUL};
                     state_ff   <= S_STREAM_MUL;
                  end else if (req_op == OP_INTEGER && range_empty) begin
                     res_int_ff       <= req_low;
                     res_hit_ff       <= 1'b0;
                     mul_req_ff.start <= 1'b0;
                     state_ff         <= S_FINISH;
                  end else if (req_op == OP_CHANCE && (req_prob == '0 || req_prob[FracW])) begin
                     res_int_ff       <= '0;
                     res_hit_ff       <= req_prob[FracW];
                     mul_req_ff.start <= 1'b0;
                     state_ff         <= S_FINISH;
                  end else begin
                     // draw, integer or chance: advance state, then scramble
                     res_int_ff   <= '0;
                     res_hit_ff   <= 1'b0;
                     gen_state_ff <= xs_next;
                     mul_req_ff   <= '{start: 1'b1, a: xs_next, b: SCRAMBLE};
                     state_ff     <= S_SCRAMBLE;
                  end
               end else begin
                  mul_req_ff.start <= 1'b0;
               end
            end
            S_STREAM_MUL: begin
               mod_req_ff.start <= 1'b0;
               if (mul_rsp.done) begin
                  work_ff    <= identity_ff ^ {stream_ff, {(WordW - StreamW){1'b0}}}
                                ^ mul_rsp.product;
                  mul_req_ff <= '{start: 1'b1,
                                  a: WordW'({1'b0, variant_ff} + SpanW'(1)),
                                  b: VARIANT_MUL};
                  state_ff   <= S_VARIANT_MUL;
               end else begin
                  mul_req_ff.start <= 1'b0;
               end
            end
            S_VARIANT_MUL: begin
               mod_req_ff.start <= 1'b0;
               if (mul_rsp.done) begin
                  mul_req_ff <= '{start: 1'b1, a: mix_a_op, b: MIX_A};
                  state_ff   <= S_MIX_A;
               end else begin
                  mul_req_ff.start <= 1'b0;
               end
            end
            S_MIX_A: begin
               mod_req_ff.start <= 1'b0;
               if (mul_rsp.done) begin
                  mul_req_ff <= '{start: 1'b1, a: mix_b_op, b: MIX_B};
                  state_ff   <= S_MIX_B;
               end else begin
                  mul_req_ff.start <= 1'b0;
               end
            end
            // final fold; an all-zero seed would lock the generator
            S_MIX_B: begin
               mul_req_ff.start <= 1'b0;
               mod_req_ff.start <= 1'b0;
               if (mul_rsp.done) begin
                  gen_state_ff <= (mix_out == '0) ? SEED_GAMMA : mix_out;
                  res_adv_ff   <= 1'b1;
                  init_ff      <= 1'b0;
                  state_ff     <= init_ff ? S_IDLE : S_FINISH;
               end
            end
            S_SCRAMBLE: begin
               mul_req_ff.start <= 1'b0;
               if (mul_rsp.done) begin
                  res_raw_ff <= mul_rsp.product;
                  res_adv_ff <= 1'b1;
                  if (op_ff == OP_INTEGER) begin
                     mod_req_ff <= '{start: 1'b1, dividend: mul_rsp.product,
                                     divisor: span_ff};
                     state_ff   <= S_MODULO;
                  end else begin
                     mod_req_ff.start <= 1'b0;
                     res_hit_ff <= (op_ff == OP_CHANCE)
                                   && (mul_rsp.product[WordW-1 -: FracW] < prob_ff);
                     state_ff   <= S_FINISH;
                  end
               end else begin
                  mod_req_ff.start <= 1'b0;
               end
            end
            S_MODULO: begin
               mul_req_ff.start <= 1'b0;
               mod_req_ff.start <= 1'b0;
               if (mod_rsp.done) begin
                  res_int_ff <= low_ff + mod_rsp.remainder;
                  state_ff   <= S_FINISH;
               end
            end
            // wait for the output register
            S_FINISH: begin
               mul_req_ff.start <= 1'b0;
               mod_req_ff.start <= 1'b0;
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               mul_req_ff.start <= 1'b0;
               mod_req_ff.start <= 1'b0;
               state_ff         <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // csr write transfer
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         identity_ff <= '0;
         stream_ff   <= '0;
         variant_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[CsrAddrW-1:3])
            CSR_IDENTITY: identity_ff <= csr_pwdata;
            CSR_STREAM:   stream_ff   <= csr_pwdata[StreamW-1:0];
            CSR_VARIANT:  variant_ff  <= csr_pwdata[IntW-1:0];
            default: begin
            end
         endcase
      end
   end

   // csr read mux
   always_comb begin
      unique case (csr_paddr[CsrAddrW-1:3])
         CSR_IDENTITY: csr_prdata = identity_ff;
         CSR_STREAM:   csr_prdata = CsrDataW'(stream_ff);
         CSR_VARIANT:  csr_prdata = CsrDataW'(variant_ff);
         default:      csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire
